>>> sv/olpe_pkg.sv
`default_nettype none

package olpe_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_ERASE = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // per-cycle command strobes broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic erase;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> sv/olpe_if.sv
`default_nettype none

// command channel
interface olpe_in_if;
    logic                          valid;
    logic                          ready;
    logic [olpe_pkg::FUNC_W-1:0]   func;
    logic signed [olpe_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// result channel
interface olpe_out_if;
    logic                            valid;
    logic                            ready;
    logic [olpe_pkg::STATUS_W-1:0]   status;
    logic [olpe_pkg::COUNT_W-1:0]    count;
    logic signed [olpe_pkg::VALUE_W-1:0] front_value;
    logic signed [olpe_pkg::VALUE_W-1:0] back_value;

    modport source (output valid, output status, output count, output front_value,
                    output back_value, input ready);
    modport sink   (input valid, input status, input count, input front_value,
                    input back_value, output ready);
endinterface

`default_nettype wire

>>> sv/ordered_list_push_pop_erase.sv
`default_nettype none

// Ordered list of up to DEPTH values held in a row of cells, each cell one entry.
// Commands: push back, pop back, erase first match (the entries behind it shift
// one cell toward the front), and clear. Every command returns one transaction
// with status, new count and front/back values (zero when empty). Accepting a
// command updates the cell row and sets a pending flag, which then loads the
// output register from the updated row; a new command waits until that load is
// done and the held result is being taken. Push to a full list, pop or erase on an
// empty list and erase without a match leave the list unchanged.
module ordered_list_push_pop_erase #(
    parameter int DEPTH      = olpe_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olpe_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olpe_in_if.sink    i_in,
    olpe_out_if.source o_out
);
    import olpe_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    t_status               r_status;
    t_status               n_status;
    logic                  r_pend;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [COUNT_W-1:0]    r_out_count;
    logic [VALUE_W-1:0]    r_out_front;
    logic [VALUE_W-1:0]    r_out_back;

    logic                  w_acc;
    t_func                 w_func;
    logic [63:0]           w_value64;
    logic [DATA_WIDTH-1:0] w_data;
    t_cell_ctl             w_ctl;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_found;

    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_hit;
    logic [DEPTH-1:0]      w_prev_valid;
    logic [DEPTH-1:0]      w_hit_in;
    logic [DEPTH:0]        w_valid_ext;
    logic [DATA_WIDTH-1:0] w_entry [DEPTH+1];
    logic [DATA_WIDTH-1:0] w_back_part [DEPTH];
    logic [DATA_WIDTH-1:0] w_back;
    logic [DATA_WIDTH-1:0] w_front;

    // command decode
    assign i_in.ready = i_rst_n && !r_pend && (!r_out_valid || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_func     = t_func'(i_in.func);
    assign w_value64  = 64'($unsigned(i_in.value));
    assign w_data     = w_value64[DATA_WIDTH-1:0];
    assign w_full     = (r_fill == FILL_W'(DEPTH));
    assign w_empty    = (r_fill == '0);
    assign w_found    = w_hit[DEPTH-1];

    always_comb begin
        w_ctl       = '0;
        w_ctl.push  = w_acc && (w_func == FUNC_PUSH);
        w_ctl.pop   = w_acc && (w_func == FUNC_POP);
        w_ctl.erase = w_acc && (w_func == FUNC_ERASE);
        w_ctl.clear = w_acc && (w_func == FUNC_CLEAR);
    end

    // neighbor wiring along the row
    assign w_prev_valid      = {w_valid[DEPTH-2:0], 1'b1};
    assign w_hit_in          = {w_hit[DEPTH-2:0], 1'b0};
    assign w_valid_ext       = {1'b0, w_valid};
    assign w_entry[DEPTH]    = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        olpe_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_data       (w_data),
            .i_prev_valid (w_prev_valid[g]),
            .i_hit_in     (w_hit_in[g]),
            .i_next_entry (w_entry[g+1]),
            .i_next_valid (w_valid_ext[g+1]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g]),
            .o_back_entry (w_back_part[g])
        );
    end

    // status and new fill
    always_comb begin
        n_fill   = r_fill;
        n_status = ST_DONE;
        case (w_func)
            FUNC_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            FUNC_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            FUNC_ERASE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // front and back of the updated row
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | w_back_part[i];
        end
        w_front = w_valid[0] ? w_entry[0] : '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_fill <= n_fill;
            end
            r_pend <= w_acc;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
        end
        if (r_pend) begin
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_fill);
            r_out_front  <= 32'(64'(w_front));
            r_out_back   <= 32'(64'(w_back));
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.count       = r_out_count;
    assign o_out.front_value = $signed(r_out_front);
    assign o_out.back_value  = $signed(r_out_back);

endmodule

`default_nettype wire

>>> sv/olpe_cell.sv
`default_nettype none

module olpe_cell #(
    parameter int DATA_WIDTH = olpe_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  olpe_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_prev_valid,
    input  logic                  i_hit_in,
    input  logic [DATA_WIDTH-1:0] i_next_entry,
    input  logic                  i_next_valid,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_back_entry
);
    import olpe_pkg::*;

    logic [DATA_WIDTH-1:0] r_entry;
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] n_entry;
    logic                  n_valid;
    logic                  w_match;
    logic                  w_is_last;

    // first-match search ripples from the front
    assign w_match   = r_valid && (r_entry == i_data);
    assign o_hit     = i_hit_in || w_match;
    assign w_is_last = r_valid && !i_next_valid;

    // next entry and occupancy
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.push && !r_valid && i_prev_valid) begin
            n_entry = i_data;
            n_valid = 1'b1;
        end
        if (i_ctl.pop && w_is_last) begin
            n_valid = 1'b0;
        end
        if (i_ctl.erase && o_hit && r_valid) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_valid      = r_valid;
    assign o_back_entry = w_is_last ? r_entry : '0;

endmodule

`default_nettype wire

>>> verif/ordered_list_push_pop_erase_test.sv
`timescale 1ns / 100ps

module ordered_list_push_pop_erase_test;

    import olpe_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int N_RANDOM   = 450;

    // expected result of one command
    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
    } t_list_result;

    // shadow copy of the list plus the results still owed by the block
    class ordered_list_tracker;
        logic [VALUE_W-1:0] shadow_list[$];
        t_list_result       expected_results[$];
        int                 errors;
        int                 n_commands;
        int                 n_checked;
        int                 n_full;
        int                 n_empty;
        int                 n_miss;

        function new();
            errors     = 0;
            n_commands = 0;
            n_checked  = 0;
            n_full     = 0;
            n_empty    = 0;
            n_miss     = 0;
        endfunction

        // apply an accepted command to the shadow list and queue its result
        function void note_command(t_func cmd, logic [VALUE_W-1:0] value);
            t_list_result res;
            int           hit;
            hit        = -1;
            res.status = ST_DONE;
            case (cmd)
                FUNC_PUSH: begin
                    if (shadow_list.size() >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        shadow_list.push_back(value);
                    end
                end
                FUNC_POP: begin
                    if (shadow_list.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        void'(shadow_list.pop_back());
                    end
                end
                FUNC_ERASE: begin
                    if (shadow_list.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        // first match from the front wins
                        foreach (shadow_list[i]) begin
                            if (hit < 0 && shadow_list[i] == value) begin
                                hit = i;
                            end
                        end
                        if (hit < 0) begin
                            res.status = ST_NOT_FOUND;
                        end else begin
                            shadow_list.delete(hit);
                        end
                    end
                end
                default: begin
                    shadow_list.delete();
                end
            endcase
            case (res.status)
                ST_FULL:      n_full++;
                ST_EMPTY:     n_empty++;
                ST_NOT_FOUND: n_miss++;
                default: ;
            endcase
            res.count = COUNT_W'(shadow_list.size());
            if (shadow_list.size() == 0) begin
                res.front_value = '0;
                res.back_value  = '0;
            end else begin
                res.front_value = shadow_list[0];
                res.back_value  = shadow_list[shadow_list.size() - 1];
            end
            expected_results.push_back(res);
            n_commands++;
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                                   logic [VALUE_W-1:0] front_value,
                                   logic [VALUE_W-1:0] back_value);
            t_list_result res;
            if (expected_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                errors++;
                return;
            end
            res = expected_results.pop_front();
            compare_field("status", VALUE_W'(res.status), VALUE_W'(status));
            compare_field("count", VALUE_W'(res.count), VALUE_W'(count));
            compare_field("front_value", res.front_value, front_value);
            compare_field("back_value", res.back_value, back_value);
            n_checked++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    olpe_in_if  cmd_if ();
    olpe_out_if res_if ();

    ordered_list_push_pop_erase dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    ordered_list_tracker tracker;
    bit                  send_calm;
    bit                  recv_calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // wait length for one side, with occasional stretches of no idling
    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 5));
    endfunction

    // often small values, and often the two extremes, so that duplicates and hits are common
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0, 1:    return VALUE_W'(int'($urandom_range(0, 7)) - 4);
            2, 3:    return $urandom;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    // present one command and hold it until the block takes it
    task automatic send_command(t_func cmd, logic [VALUE_W-1:0] value);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            send_calm = !send_calm;
        end
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= cmd;
        cmd_if.value <= value;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    // pick an erase key, usually one that is in the list
    function automatic logic [VALUE_W-1:0] pick_key();
        int n;
        n = tracker.shadow_list.size();
        if (n > 0 && $urandom_range(0, 3) != 0) begin
            return tracker.shadow_list[$urandom_range(0, n - 1)];
        end
        return pick_value();
    endfunction

    // result side: random stalls on ready
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                recv_calm = !recv_calm;
            end
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // monitor: note accepted commands, then check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                tracker.note_command(t_func'(cmd_if.func), cmd_if.value);
            end
            if (res_if.valid && res_if.ready) begin
                tracker.check_result(res_if.status, res_if.count,
                                     res_if.front_value, res_if.back_value);
            end
        end
    end

    // stimulus
    initial begin
        logic [VALUE_W-1:0] fill_vals[16];
        int                 roll;
        int                 push_lim;
        int                 pop_lim;
        bit                 fill_phase;
        tracker      = new();
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.func  <= FUNC_PUSH;
        cmd_if.value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: clear, pop and erase all leave it empty
        send_command(FUNC_CLEAR, 32'h0000_0000);
        send_command(FUNC_POP, 32'hffff_ffff);
        send_command(FUNC_ERASE, 32'd5);

        // fill to capacity with extremes and repeated keys
        fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'd5, 32'd9, 32'd5, 32'd1, 32'd2, 32'd3, 32'd5, 32'd4,
                      32'd6, 32'd7, 32'd8, 32'h55aa_55aa};
        foreach (fill_vals[i]) begin
            send_command(FUNC_PUSH, fill_vals[i]);
        end
        // full list refuses the push
        send_command(FUNC_PUSH, 32'd99);
        // several matches: only the front-most goes
        send_command(FUNC_ERASE, 32'd5);
        // erase of the back entry
        send_command(FUNC_ERASE, 32'h55aa_55aa);
        // key not present
        send_command(FUNC_ERASE, 32'd12345);
        send_command(FUNC_POP, 32'h0);
        send_command(FUNC_CLEAR, 32'h0);

        // random part: alternating fill-heavy and drain-heavy phases
        for (int n = 0; n < N_RANDOM; n++) begin
            fill_phase = ((n / 60) % 2) == 0;
            push_lim   = fill_phase ? 63 : 33;
            pop_lim    = fill_phase ? 78 : 63;
            roll       = $urandom_range(0, 99);
            if (roll < 3) begin
                send_command(FUNC_CLEAR, pick_value());
            end else if (roll < push_lim) begin
                send_command(FUNC_PUSH, pick_value());
            end else if (roll < pop_lim) begin
                send_command(FUNC_POP, pick_value());
            end else begin
                send_command(FUNC_ERASE, pick_key());
            end
        end
        cmd_if.valid <= 1'b0;

        // drain, then wait quietly for anything unexpected
        while (tracker.expected_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d commands, %0d results checked", tracker.n_commands,
                 tracker.n_checked);
        $display("refused: %0d full, %0d empty, %0d key missing", tracker.n_full,
                 tracker.n_empty, tracker.n_miss);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> ordered_list_push_pop_erase.f
sv/olpe_pkg.sv
sv/olpe_if.sv
sv/olpe_cell.sv
sv/ordered_list_push_pop_erase.sv
verif/ordered_list_push_pop_erase_test.sv
